// ===== design/vlad_pkg.sv =====
// Shared types, constants and a width helper for the V-I loop area block.
package vlad_pkg;

   localparam int FIELD_W         = 16;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int AREA_W          = 38;
   localparam int ABS_SUM_W       = 39;
   localparam int SGN_SUM_W       = 41;
   localparam int SGN_MAG_W       = 40;

   typedef enum logic [1:0] {
      DIR_ZERO = 2'd0,
      DIR_POS  = 2'd1,
      DIR_NEG  = 2'd2
   } dir_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic cont;
   } stage_ctl_type;

   function automatic int sum_width(input int sb);
      int w;
      w = 2 * sb + 3;
      if (w < SGN_SUM_W + 1) begin
         w = SGN_SUM_W + 1;
      end
      return w;
   endfunction

endpackage

// ===== design/vlad_prod.sv =====
// Input register, loop point tracking and cross-product multipliers.
module vlad_prod #(
   parameter int SAMPLE_BITS = vlad_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [vlad_pkg::FIELD_W-1:0] req_volt,
   input  logic signed [vlad_pkg::FIELD_W-1:0] req_curr,
   input  logic                               req_last,
   output vlad_pkg::stage_ctl_type            out_ctl,
   output logic signed [2*SAMPLE_BITS-1:0]    out_pv_ci,
   output logic signed [2*SAMPLE_BITS-1:0]    out_cv_pi,
   output logic signed [2*SAMPLE_BITS-1:0]    out_cv_fi,
   output logic signed [2*SAMPLE_BITS-1:0]    out_fv_ci,
   input  logic                               out_ready
);

   localparam int SB = SAMPLE_BITS;
   localparam int PW = 2 * SAMPLE_BITS;
   localparam int LB = (SAMPLE_BITS < vlad_pkg::FIELD_W) ? SAMPLE_BITS : vlad_pkg::FIELD_W;

   logic signed [SB-1:0] volt_x;
   logic signed [SB-1:0] curr_x;

   logic                 s1_valid_ff;
   logic                 s1_last_ff;
   logic signed [SB-1:0] s1_volt_ff;
   logic signed [SB-1:0] s1_curr_ff;

   logic                 in_cycle_ff;
   logic signed [SB-1:0] prev_volt_ff;
   logic signed [SB-1:0] prev_curr_ff;
   logic signed [SB-1:0] first_volt_ff;
   logic signed [SB-1:0] first_curr_ff;

   vlad_pkg::stage_ctl_type s2_ctl_ff;
   vlad_pkg::stage_ctl_type s2_ctl_in;
   logic signed [PW-1:0]    pv_ci_ff;
   logic signed [PW-1:0]    cv_pi_ff;
   logic signed [PW-1:0]    cv_fi_ff;
   logic signed [PW-1:0]    fv_ci_ff;

   logic signed [PW-1:0] pv_ci_in;
   logic signed [PW-1:0] cv_pi_in;
   logic signed [PW-1:0] cv_fi_in;
   logic signed [PW-1:0] fv_ci_in;

   logic s2_ready;
   logic s1_ready;
   logic s1_go;
   logic accept;

   assign volt_x = $signed(SB'(req_volt[LB-1:0]));
   assign curr_x = $signed(SB'(req_curr[LB-1:0]));

   assign s2_ready  = !s2_ctl_ff.valid || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s1_go     = s1_valid_ff && s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   assign pv_ci_in = prev_volt_ff * s1_curr_ff;
   assign cv_pi_in = s1_volt_ff * prev_curr_ff;
   assign cv_fi_in = s1_volt_ff * first_curr_ff;
   assign fv_ci_in = first_volt_ff * s1_curr_ff;

   always_comb begin
      s2_ctl_in.valid = s1_valid_ff;
      s2_ctl_in.last  = s1_last_ff;
      s2_ctl_in.cont  = in_cycle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         in_cycle_ff <= 1'b0;
         s2_ctl_ff   <= '0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_go) begin
            in_cycle_ff <= !s1_last_ff;
         end
         if (s2_ready) begin
            s2_ctl_ff <= s2_ctl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_volt_ff <= volt_x;
         s1_curr_ff <= curr_x;
         s1_last_ff <= req_last;
      end
      if (s1_go) begin
         prev_volt_ff <= s1_volt_ff;
         prev_curr_ff <= s1_curr_ff;
         if (!in_cycle_ff) begin
            first_volt_ff <= s1_volt_ff;
            first_curr_ff <= s1_curr_ff;
         end
         pv_ci_ff <= pv_ci_in;
         cv_pi_ff <= cv_pi_in;
         cv_fi_ff <= cv_fi_in;
         fv_ci_ff <= fv_ci_in;
      end
   end

   assign out_ctl   = s2_ctl_ff;
   assign out_pv_ci = pv_ci_ff;
   assign out_cv_pi = cv_pi_ff;
   assign out_cv_fi = cv_fi_ff;
   assign out_fv_ci = fv_ci_ff;

endmodule

// ===== design/vlad_term.sv =====
// Cross terms, their magnitudes, the pre-added sums and the clamped candidates for the accumulator.
module vlad_term #(
   parameter int SAMPLE_BITS = vlad_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  vlad_pkg::stage_ctl_type                     in_ctl,
   input  logic signed [2*SAMPLE_BITS-1:0]             in_pv_ci,
   input  logic signed [2*SAMPLE_BITS-1:0]             in_cv_pi,
   input  logic signed [2*SAMPLE_BITS-1:0]             in_cv_fi,
   input  logic signed [2*SAMPLE_BITS-1:0]             in_fv_ci,
   output logic                                        in_ready,
   output vlad_pkg::stage_ctl_type                     out_ctl,
   output logic [vlad_pkg::sum_width(SAMPLE_BITS)-1:0] out_a12,
   output logic signed [vlad_pkg::sum_width(SAMPLE_BITS)-1:0] out_c1,
   output logic signed [vlad_pkg::sum_width(SAMPLE_BITS)-1:0] out_c12,
   output logic signed [vlad_pkg::SGN_SUM_W-1:0]       out_cand_hi,
   output logic signed [vlad_pkg::SGN_SUM_W-1:0]       out_cand_lo,
   input  logic                                        out_ready
);

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int CW = 2 * SAMPLE_BITS + 1;
   localparam int XW = vlad_pkg::sum_width(SAMPLE_BITS);
   localparam int SW = vlad_pkg::SGN_SUM_W;
   localparam logic signed [XW-1:0] SLIM =
      {{(XW-vlad_pkg::SGN_MAG_W){1'b0}}, {vlad_pkg::SGN_MAG_W{1'b1}}};
   localparam logic signed [XW-1:0] NLIM = -SLIM;

   vlad_pkg::stage_ctl_type s3_ctl_ff;
   logic signed [CW-1:0]    c1_ff;
   logic signed [CW-1:0]    c2_ff;
   logic [CW-1:0]           a1_ff;
   logic [CW-1:0]           a2_ff;

   vlad_pkg::stage_ctl_type s4_ctl_ff;
   logic [XW-1:0]           a12_ff;
   logic signed [XW-1:0]    c1x_ff;
   logic signed [XW-1:0]    c12_ff;
   logic signed [SW-1:0]    cand_hi_ff;
   logic signed [SW-1:0]    cand_lo_ff;

   logic signed [CW-1:0] d1_pos;
   logic signed [CW-1:0] d1_neg;
   logic signed [CW-1:0] d2_pos;
   logic signed [CW-1:0] d2_neg;
   logic signed [CW-1:0] c1_in;
   logic signed [CW-1:0] c2_in;
   logic [CW-1:0]        a1_in;
   logic [CW-1:0]        a2_in;

   logic [XW-1:0]        a12_in;
   logic signed [XW-1:0] c1x_in;
   logic signed [XW-1:0] c2x;
   logic signed [XW-1:0] c12_in;
   logic signed [XW-1:0] hi_raw;
   logic signed [XW-1:0] lo_raw;
   logic signed [SW-1:0] cand_hi_in;
   logic signed [SW-1:0] cand_lo_in;

   logic s4_ready;
   logic s3_ready;
   logic use_c1;
   logic use_c2;

   assign s4_ready = !s4_ctl_ff.valid || out_ready;
   assign s3_ready = !s3_ctl_ff.valid || s4_ready;
   assign in_ready = s3_ready;

   assign d1_pos = $signed({in_pv_ci[PW-1], in_pv_ci}) - $signed({in_cv_pi[PW-1], in_cv_pi});
   assign d1_neg = $signed({in_cv_pi[PW-1], in_cv_pi}) - $signed({in_pv_ci[PW-1], in_pv_ci});
   assign d2_pos = $signed({in_cv_fi[PW-1], in_cv_fi}) - $signed({in_fv_ci[PW-1], in_fv_ci});
   assign d2_neg = $signed({in_fv_ci[PW-1], in_fv_ci}) - $signed({in_cv_fi[PW-1], in_cv_fi});

   assign use_c1 = in_ctl.cont;
   assign use_c2 = in_ctl.cont && in_ctl.last;

   always_comb begin
      c1_in = use_c1 ? d1_pos : '0;
      c2_in = use_c2 ? d2_pos : '0;
      a1_in = '0;
      a2_in = '0;
      if (use_c1) begin
         a1_in = d1_pos[CW-1] ? d1_neg : d1_pos;
      end
      if (use_c2) begin
         a2_in = d2_pos[CW-1] ? d2_neg : d2_pos;
      end
   end

   assign a12_in = {{(XW-CW){1'b0}}, a1_ff} + {{(XW-CW){1'b0}}, a2_ff};
   assign c1x_in = {{(XW-CW){c1_ff[CW-1]}}, c1_ff};
   assign c2x    = {{(XW-CW){c2_ff[CW-1]}}, c2_ff};
   assign c12_in = c1x_in + c2x;
   assign hi_raw = SLIM + c2x;
   assign lo_raw = NLIM + c2x;

   always_comb begin
      if (hi_raw > SLIM) begin
         cand_hi_in = SLIM[SW-1:0];
      end else if (hi_raw < NLIM) begin
         cand_hi_in = NLIM[SW-1:0];
      end else begin
         cand_hi_in = hi_raw[SW-1:0];
      end
      if (lo_raw > SLIM) begin
         cand_lo_in = SLIM[SW-1:0];
      end else if (lo_raw < NLIM) begin
         cand_lo_in = NLIM[SW-1:0];
      end else begin
         cand_lo_in = lo_raw[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
         s4_ctl_ff <= '0;
      end else begin
         if (s3_ready) begin
            s3_ctl_ff <= in_ctl;
         end
         if (s4_ready) begin
            s4_ctl_ff <= s3_ctl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_ctl.valid) begin
         c1_ff <= c1_in;
         c2_ff <= c2_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
      end
      if (s4_ready && s3_ctl_ff.valid) begin
         a12_ff     <= a12_in;
         c1x_ff     <= c1x_in;
         c12_ff     <= c12_in;
         cand_hi_ff <= cand_hi_in;
         cand_lo_ff <= cand_lo_in;
      end
   end

   assign out_ctl     = s4_ctl_ff;
   assign out_a12     = a12_ff;
   assign out_c1      = c1x_ff;
   assign out_c12     = c12_ff;
   assign out_cand_hi = cand_hi_ff;
   assign out_cand_lo = cand_lo_ff;

endmodule

// ===== design/vlad_accum.sv =====
// Saturating loop accumulators and the result register.
module vlad_accum #(
   parameter int SAMPLE_BITS = vlad_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  vlad_pkg::stage_ctl_type                     in_ctl,
   input  logic [vlad_pkg::sum_width(SAMPLE_BITS)-1:0] in_a12,
   input  logic signed [vlad_pkg::sum_width(SAMPLE_BITS)-1:0] in_c1,
   input  logic signed [vlad_pkg::sum_width(SAMPLE_BITS)-1:0] in_c12,
   input  logic signed [vlad_pkg::SGN_SUM_W-1:0]       in_cand_hi,
   input  logic signed [vlad_pkg::SGN_SUM_W-1:0]       in_cand_lo,
   output logic                                        in_ready,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic [vlad_pkg::AREA_W-1:0]                 rsp_area,
   output logic [1:0]                                  rsp_direction,
   output logic                                        rsp_overflow
);

   localparam int XW = vlad_pkg::sum_width(SAMPLE_BITS);
   localparam int SW = vlad_pkg::SGN_SUM_W;
   localparam int AB = vlad_pkg::ABS_SUM_W;
   localparam logic signed [XW-1:0] SLIM =
      {{(XW-vlad_pkg::SGN_MAG_W){1'b0}}, {vlad_pkg::SGN_MAG_W{1'b1}}};
   localparam logic signed [XW-1:0] NLIM = -SLIM;
   localparam logic [XW-1:0] ALIM = {{(XW-AB){1'b0}}, {AB{1'b1}}};

   logic [AB-1:0]        abs_sum_ff;
   logic signed [SW-1:0] sgn_sum_ff;
   logic                 sat_ff;

   logic                 rsp_valid_ff;
   logic [vlad_pkg::AREA_W-1:0] area_ff;
   vlad_pkg::dir_type    dir_ff;
   logic                 overflow_ff;

   logic [AB-1:0]        abs_base;
   logic signed [SW-1:0] sgn_base;
   logic [XW-1:0]        abs_raw;
   logic signed [XW-1:0] sgn_x;
   logic signed [XW-1:0] sgn_y;
   logic [AB-1:0]        abs_sum_in;
   logic signed [SW-1:0] sgn_sum_in;
   logic                 sat_in;
   logic                 abs_sat;
   logic                 sgn_sat;
   vlad_pkg::dir_type    dir_in;

   logic out_free;
   logic go;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign in_ready = !in_ctl.last || out_free;
   assign go       = in_ctl.valid && in_ready;

   assign abs_base = in_ctl.cont ? abs_sum_ff : '0;
   assign sgn_base = in_ctl.cont ? sgn_sum_ff : '0;
   assign abs_raw  = {{(XW-AB){1'b0}}, abs_base} + in_a12;
   assign sgn_x    = {{(XW-SW){sgn_base[SW-1]}}, sgn_base} + in_c1;
   assign sgn_y    = {{(XW-SW){sgn_base[SW-1]}}, sgn_base} + in_c12;

   always_comb begin
      abs_sat    = abs_raw > ALIM;
      abs_sum_in = abs_sat ? ALIM[AB-1:0] : abs_raw[AB-1:0];
      sgn_sat    = 1'b1;
      if (sgn_x > SLIM) begin
         sgn_sum_in = in_cand_hi;
      end else if (sgn_x < NLIM) begin
         sgn_sum_in = in_cand_lo;
      end else if (sgn_y > SLIM) begin
         sgn_sum_in = SLIM[SW-1:0];
      end else if (sgn_y < NLIM) begin
         sgn_sum_in = NLIM[SW-1:0];
      end else begin
         sgn_sum_in = sgn_y[SW-1:0];
         sgn_sat    = 1'b0;
      end
      sat_in = (in_ctl.cont && sat_ff) || abs_sat || sgn_sat;
   end

   always_comb begin
      if (sgn_sum_in > 0) begin
         dir_in = vlad_pkg::DIR_POS;
      end else if (sgn_sum_in < 0) begin
         dir_in = vlad_pkg::DIR_NEG;
      end else begin
         dir_in = vlad_pkg::DIR_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && in_ctl.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         abs_sum_ff <= abs_sum_in;
         sgn_sum_ff <= sgn_sum_in;
         sat_ff     <= sat_in;
         if (in_ctl.last) begin
            area_ff     <= abs_sum_in[AB-1:1];
            dir_ff      <= dir_in;
            overflow_ff <= sat_in;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_area      = area_ff;
   assign rsp_direction = dir_ff;
   assign rsp_overflow  = overflow_ff;

endmodule

// ===== design/vi_loop_area_direction_top.sv =====
// Top level of the V-I loop area and direction block.
//
// Streams one waveform cycle of (volt, curr) sample pairs, the final one marked
// by req_last, and returns one result item per waveform cycle with the shoelace
// area (half the sum of absolute cross products, Q2.30 units), the loop
// direction from the sign of the signed sum, and an overflow flag if either
// saturating accumulator clamped during the cycle. One sample is taken every
// clock while req_stall is low. A last sample passes the input, product and
// term registers before the accumulator registers its result item. Samples
// keep flowing while a result waits in the output register, until the next last
// sample reaches the accumulator; that sample then holds the pipeline.
module vi_loop_area_direction_top #(
   parameter int SAMPLE_BITS = vlad_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [vlad_pkg::FIELD_W-1:0] req_volt,
   input  logic signed [vlad_pkg::FIELD_W-1:0] req_curr,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [vlad_pkg::AREA_W-1:0]         rsp_area,
   output logic [1:0]                         rsp_direction,
   output logic                               rsp_overflow
);

   localparam int PW = 2 * SAMPLE_BITS;
   localparam int XW = vlad_pkg::sum_width(SAMPLE_BITS);
   localparam int SW = vlad_pkg::SGN_SUM_W;

   vlad_pkg::stage_ctl_type prod_ctl;
   logic signed [PW-1:0]    pv_ci;
   logic signed [PW-1:0]    cv_pi;
   logic signed [PW-1:0]    cv_fi;
   logic signed [PW-1:0]    fv_ci;
   logic                    term_ready;

   vlad_pkg::stage_ctl_type term_ctl;
   logic [XW-1:0]           a12;
   logic signed [XW-1:0]    c1;
   logic signed [XW-1:0]    c12;
   logic signed [SW-1:0]    cand_hi;
   logic signed [SW-1:0]    cand_lo;
   logic                    accum_ready;

   vlad_prod #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_prod (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_volt  (req_volt),
      .req_curr  (req_curr),
      .req_last  (req_last),
      .out_ctl   (prod_ctl),
      .out_pv_ci (pv_ci),
      .out_cv_pi (cv_pi),
      .out_cv_fi (cv_fi),
      .out_fv_ci (fv_ci),
      .out_ready (term_ready)
   );

   vlad_term #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_term (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (prod_ctl),
      .in_pv_ci    (pv_ci),
      .in_cv_pi    (cv_pi),
      .in_cv_fi    (cv_fi),
      .in_fv_ci    (fv_ci),
      .in_ready    (term_ready),
      .out_ctl     (term_ctl),
      .out_a12     (a12),
      .out_c1      (c1),
      .out_c12     (c12),
      .out_cand_hi (cand_hi),
      .out_cand_lo (cand_lo),
      .out_ready   (accum_ready)
   );

   vlad_accum #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (term_ctl),
      .in_a12        (a12),
      .in_c1         (c1),
      .in_c12        (c12),
      .in_cand_hi    (cand_hi),
      .in_cand_lo    (cand_lo),
      .in_ready      (accum_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_area      (rsp_area),
      .rsp_direction (rsp_direction),
      .rsp_overflow  (rsp_overflow)
   );

endmodule
